[rtl/brs_pkg.sv]
package brs_pkg;

  // Image store geometry and fixed-point format
  localparam int MAX_IMAGE_WIDTH  = 1024;
  localparam int MAX_IMAGE_HEIGHT = 1024;
  localparam int PLANES           = 3;
  localparam int FRAC_BITS        = 8;

  localparam int OUT_PLANES = 3;
  localparam int XW     = $clog2(MAX_IMAGE_WIDTH);
  localparam int YW     = $clog2(MAX_IMAGE_HEIGHT);
  localparam int IDX_W  = (XW > YW) ? XW : YW;
  localparam int BANK_AW    = (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Field and register widths
  localparam int FIELD_W = 10;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 21;
  localparam int SIZE_W  = 20;
  localparam int VAL_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Centre mapping datapath
  localparam int NUM_W   = DIM_W + SIZE_W;
  localparam int DEN_W   = DIM_W + 1;
  localparam int COORD_W = NUM_W + 2;
  localparam int INT_W   = COORD_W - FRAC_BITS;
  localparam logic [COORD_W-1:0] HALF = COORD_W'(1) << (FRAC_BITS - 1);

  // Blend datapath
  localparam int C_W       = 8 + FRAC_BITS + 2;
  localparam int R_W       = C_W + FRAC_BITS + 2;
  localparam int OUT_SHIFT = 2 * FRAC_BITS - 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_OUT_WIDTH    = 3'd2,
    REG_OUT_HEIGHT   = 3'd3,
    REG_WIN_LEFT     = 3'd4,
    REG_WIN_TOP      = 3'd5,
    REG_WIN_WIDTH    = 3'd6,
    REG_WIN_HEIGHT   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [FIELD_W-1:0]   texel_col;
    logic [FIELD_W-1:0]   texel_row;
    logic [1:0]           plane;
    logic [7:0]           texel_value;
    logic [FIELD_W-1:0]   out_col;
    logic [FIELD_W-1:0]   out_row;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sample_col;
    logic [FIELD_W-1:0] sample_row;
    logic [VAL_W-1:0]   value_plane0;
    logic [VAL_W-1:0]   value_plane1;
    logic [VAL_W-1:0]   value_plane2;
  } out_item_t;

  typedef struct packed {
    cfg_index_t         index;
    logic [POS_W-1:0]   value;
  } cfg_write_t;

  typedef struct packed {
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
    logic [DIM_W-1:0]         out_width;
    logic [DIM_W-1:0]         out_height;
    logic signed [POS_W-1:0]  win_left;
    logic signed [POS_W-1:0]  win_top;
    logic [SIZE_W-1:0]        win_width;
    logic [SIZE_W-1:0]        win_height;
  } cfg_t;

  // Work handed from front to back
  typedef struct packed {
    logic                 is_sample;
    logic [FIELD_W-1:0]   texel_col;
    logic [FIELD_W-1:0]   texel_row;
    logic [1:0]           plane;
    logic [7:0]           texel_value;
    logic [FIELD_W-1:0]   sample_col;
    logic [FIELD_W-1:0]   sample_row;
    logic [XW-1:0]        x0;
    logic [XW-1:0]        x1;
    logic [YW-1:0]        y0;
    logic [YW-1:0]        y1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } job_t;

  // Largest legal index for an image size register
  function automatic logic [IDX_W-1:0] limit_hi(input logic [DIM_W-1:0] w, input int maxv);
    logic [IDX_W-1:0] hi;
    if (w == '0) begin
      hi = '0;
    end else if (int'(w) > maxv) begin
      hi = IDX_W'(maxv - 1);
    end else begin
      hi = IDX_W'(w - 1'b1);
    end
    return hi;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_index(input logic signed [INT_W:0] v,
                                                    input logic [IDX_W-1:0] hi);
    logic [IDX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed((INT_W+1)'(hi))) begin
      r = hi;
    end else begin
      r = v[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/brs_if.sv]
interface brs_in_if;
  logic               valid;
  logic               ready;
  brs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brs_out_if;
  logic               valid;
  logic               ready;
  brs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brs_cfg_if;
  logic                valid;
  logic                ready;
  brs_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/brs_divider.sv]
module brs_divider (
  input  logic                        clk,
  input  logic                        en,
  input  logic [brs_pkg::NUM_W-1:0]   num,
  input  logic [brs_pkg::DEN_W-1:0]   den,
  output logic [brs_pkg::NUM_W-1:0]   quot
);
  import brs_pkg::*;

  // One quotient bit per stage, MSB first
  localparam int S = NUM_W;

  logic [DEN_W-1:0] rem_q [S];
  logic [NUM_W-1:0] num_q [S];
  logic [NUM_W-1:0] quo_q [S];
  logic [DEN_W-1:0] rem_next [S];
  logic [NUM_W-1:0] num_next [S];
  logic [NUM_W-1:0] quo_next [S];

  always_comb begin
    logic [DEN_W-1:0] src_rem;
    logic [NUM_W-1:0] src_num;
    logic [NUM_W-1:0] src_quo;
    logic [DEN_W:0]   trial;
    for (int k = 0; k < S; k++) begin
      src_rem = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k-1];
      src_num = (k == 0) ? num : num_q[(k == 0) ? 0 : k-1];
      src_quo = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k-1];
      trial = {src_rem, src_num[NUM_W-1]};
      num_next[k] = src_num << 1;
      if (trial >= {1'b0, den}) begin
        rem_next[k] = DEN_W'(trial - {1'b0, den});
        quo_next[k] = {src_quo[NUM_W-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[DEN_W-1:0];
        quo_next[k] = {src_quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < S; k++) begin
        rem_q[k] <= rem_next[k];
        num_q[k] <= num_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign quot = quo_q[S-1];

endmodule

[rtl/brs_front.sv]
module brs_front (
  input  logic           clk,
  input  logic           rst,
  input  brs_pkg::cfg_t  cfg,
  brs_in_if.sink         req,
  output logic           push_valid,
  output brs_pkg::job_t  push_job,
  input  logic           push_ready
);
  import brs_pkg::*;

  localparam int DS  = NUM_W;
  localparam int NST = DS + 3;

  logic                      adv;
  logic [NST-1:0]            vld;
  in_item_t                  itm [DS+2];
  logic [NUM_W-1:0]          nx, ny, qx, qy;
  logic [DIM_W-1:0]          ow, oh;
  logic [DEN_W-1:0]          dx, dy;
  logic signed [COORD_W-1:0] cx, cy;
  logic [IDX_W-1:0]          hi_x, hi_y;
  logic signed [INT_W:0]     ix, iy;
  job_t                      job, job_next;

  assign adv       = !vld[NST-1] || push_ready;
  assign req.ready = adv;

  assign ow = (cfg.out_width == '0) ? DIM_W'(1) : cfg.out_width;
  assign oh = (cfg.out_height == '0) ? DIM_W'(1) : cfg.out_height;
  assign dx = {ow, 1'b0};
  assign dy = {oh, 1'b0};
  assign hi_x = limit_hi(cfg.image_width, MAX_IMAGE_WIDTH);
  assign hi_y = limit_hi(cfg.image_height, MAX_IMAGE_HEIGHT);

  brs_divider u_div_x (.clk(clk), .en(adv), .num(nx), .den(dx), .quot(qx));
  brs_divider u_div_y (.clk(clk), .en(adv), .num(ny), .den(dy), .quot(qy));

  // floor by arithmetic shift, fraction is the low bits
  assign ix = (INT_W+1)'($signed(cx[COORD_W-1:FRAC_BITS]));
  assign iy = (INT_W+1)'($signed(cy[COORD_W-1:FRAC_BITS]));

  always_comb begin
    in_item_t it;
    logic [IDX_W-1:0] c0, c1, r0, r1;
    it = itm[DS+1];
    c0 = clamp_index(ix, hi_x);
    c1 = clamp_index(ix + 1'b1, hi_x);
    r0 = clamp_index(iy, hi_y);
    r1 = clamp_index(iy + 1'b1, hi_y);
    job_next.is_sample   = (it.opcode == OP_SAMPLE);
    job_next.texel_col   = it.texel_col;
    job_next.texel_row   = it.texel_row;
    job_next.plane       = it.plane;
    job_next.texel_value = it.texel_value;
    job_next.sample_col  = it.out_col;
    job_next.sample_row  = it.out_row;
    job_next.x0 = c0[XW-1:0];
    job_next.x1 = c1[XW-1:0];
    job_next.y0 = r0[YW-1:0];
    job_next.y1 = r1[YW-1:0];
    job_next.fx = cx[FRAC_BITS-1:0];
    job_next.fy = cy[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[0] <= req.data;
      nx <= NUM_W'({req.data.out_col, 1'b1}) * NUM_W'(cfg.win_width);
      ny <= NUM_W'({req.data.out_row, 1'b1}) * NUM_W'(cfg.win_height);
      for (int k = 1; k < DS + 2; k++) begin
        itm[k] <= itm[k-1];
      end
      cx <= COORD_W'(cfg.win_left) + $signed({2'b00, qx}) - $signed(HALF);
      cy <= COORD_W'(cfg.win_top) + $signed({2'b00, qy}) - $signed(HALF);
      job <= job_next;
    end
  end

  assign push_valid = vld[NST-1];
  assign push_job   = job;

endmodule

[rtl/brs_queue.sv]
module brs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  brs_pkg::job_t  push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output brs_pkg::job_t  pop_job,
  input  logic           pop_ready
);
  import brs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/brs_back.sv]
module brs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  brs_pkg::job_t  pop_job,
  output logic           pop_ready,
  brs_out_if.source      rsp
);
  import brs_pkg::*;

  logic adv, take, do_read, do_write;

  assign adv       = !rsp.valid || rsp.ready;
  assign pop_ready = adv;
  assign take      = adv && pop_valid;
  assign do_read   = take && pop_job.is_sample;
  assign do_write  = take && !pop_job.is_sample
                     && (int'(pop_job.texel_col) < MAX_IMAGE_WIDTH)
                     && (int'(pop_job.texel_row) < MAX_IMAGE_HEIGHT)
                     && (int'(pop_job.plane) < PLANES);

  // Four banks per plane by row and column parity: the 2x2 neighborhood
  // always hits each bank at most once.
  logic [XW-1:0]      wcol, csel [2];
  logic [YW-1:0]      wrow, rsel [2];
  logic [BANK_AW-1:0] waddr;
  logic [BANK_AW-1:0] raddr [2][2];
  logic [7:0]         rdata [OUT_PLANES][2][2];

  assign wcol  = XW'(pop_job.texel_col);
  assign wrow  = YW'(pop_job.texel_row);
  assign waddr = {wrow[YW-1:1], wcol[XW-1:1]};

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      csel[b] = (pop_job.x0[0] == b[0]) ? pop_job.x0 : pop_job.x1;
      rsel[b] = (pop_job.y0[0] == b[0]) ? pop_job.y0 : pop_job.y1;
    end
    for (int rb = 0; rb < 2; rb++) begin
      for (int cb = 0; cb < 2; cb++) begin
        raddr[rb][cb] = {rsel[rb][YW-1:1], csel[cb][XW-1:1]};
      end
    end
  end

  for (genvar p = 0; p < OUT_PLANES; p++) begin : g_plane
    for (genvar rb = 0; rb < 2; rb++) begin : g_row
      for (genvar cb = 0; cb < 2; cb++) begin : g_col
        if (p < PLANES) begin : g_mem
          logic [7:0] bank_mem [BANK_DEPTH];
          always_ff @(posedge clk) begin
            if (do_write && (int'(pop_job.plane) == p) && (wrow[0] == rb[0])
                && (wcol[0] == cb[0])) begin
              bank_mem[waddr] <= pop_job.texel_value;
            end
            if (do_read) begin
              rdata[p][rb][cb] <= bank_mem[raddr[rb][cb]];
            end
          end
        end else begin : g_none
          assign rdata[p][rb][cb] = '0;
        end
      end
    end
  end

  // stage 1: bank data arrives
  logic                 s1_valid;
  logic [FIELD_W-1:0]   s1_col, s1_row;
  logic [FRAC_BITS-1:0] s1_fx, s1_fy;
  logic                 s1_px0, s1_px1, s1_py0, s1_py1;

  // stage 2: horizontal blends
  logic                 s2_valid;
  logic [FIELD_W-1:0]   s2_col, s2_row;
  logic [FRAC_BITS-1:0] s2_fy;
  logic signed [C_W-1:0] s2_c1 [OUT_PLANES];
  logic signed [C_W-1:0] s2_c2 [OUT_PLANES];

  logic signed [C_W-1:0] c1_next [OUT_PLANES];
  logic signed [C_W-1:0] c2_next [OUT_PLANES];
  logic [VAL_W-1:0]      val_next [OUT_PLANES];

  always_comb begin
    logic signed [C_W-1:0] ea, eb, ec, ed;
    for (int p = 0; p < OUT_PLANES; p++) begin
      ea = C_W'({1'b0, rdata[p][s1_py0][s1_px0]});
      eb = C_W'({1'b0, rdata[p][s1_py0][s1_px1]});
      ec = C_W'({1'b0, rdata[p][s1_py1][s1_px0]});
      ed = C_W'({1'b0, rdata[p][s1_py1][s1_px1]});
      c1_next[p] = (ea <<< FRAC_BITS) + (eb - ea) * $signed({1'b0, s1_fx});
      c2_next[p] = (ec <<< FRAC_BITS) + (ed - ec) * $signed({1'b0, s1_fx});
    end
  end

  always_comb begin
    logic signed [R_W-1:0] e1, e2, r;
    for (int p = 0; p < OUT_PLANES; p++) begin
      e1 = R_W'(s2_c1[p]);
      e2 = R_W'(s2_c2[p]);
      r  = (e1 <<< FRAC_BITS) + (e2 - e1) * $signed({1'b0, s2_fy});
      if (p >= PLANES || r < 0) begin
        val_next[p] = '0;
      end else begin
        val_next[p] = r[OUT_SHIFT +: VAL_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= do_read;
      s2_valid  <= s1_valid;
      rsp.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (do_read) begin
        s1_col <= pop_job.sample_col;
        s1_row <= pop_job.sample_row;
        s1_fx  <= pop_job.fx;
        s1_fy  <= pop_job.fy;
        s1_px0 <= pop_job.x0[0];
        s1_px1 <= pop_job.x1[0];
        s1_py0 <= pop_job.y0[0];
        s1_py1 <= pop_job.y1[0];
      end
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_fy  <= s1_fy;
      for (int p = 0; p < OUT_PLANES; p++) begin
        s2_c1[p] <= c1_next[p];
        s2_c2[p] <= c2_next[p];
      end
      rsp.data.sample_col   <= s2_col;
      rsp.data.sample_row   <= s2_row;
      rsp.data.value_plane0 <= val_next[0];
      rsp.data.value_plane1 <= val_next[1];
      rsp.data.value_plane2 <= val_next[2];
    end
  end

endmodule

[rtl/bilinear_window_resampler_top.sv]
// Bilinear window resampler. Items on req either load one 8-bit texel
// (opcode load) into the on-chip texel store or ask for one output pixel of
// the window (opcode sample); every sample gives exactly one item on rsp with
// the three plane values in unsigned Q8.8, loads give none. Items are taken
// one per cycle unless req is held off, and results leave in order. The front
// registers the centre multiply, passes it through the bit-per-stage dividers
// that scale the cell centre into the window, and then registers the offset
// and then the floor and edge clamp; the four-entry queue follows, then the
// back reads the four neighbors from parity-banked texel memory, registers
// the horizontal blends and then registers the vertical blend as the result.
// Both halves stall on their own, so rsp backpressure fills the queue before
// req is held off. Loads and samples keep their order, so a sample sees every
// texel loaded before it. The store has no reset and no clearing pass: reading
// a texel that was never loaded gives an undefined value. Configuration is
// written through cfg (always ready) and must only change while no item is in
// flight.
module bilinear_window_resampler_top (
  input  logic  clk,
  input  logic  rst,
  brs_cfg_if.sink    cfg,
  brs_in_if.sink     req,
  brs_out_if.source  rsp
);
  import brs_pkg::*;

  cfg_t cfg_regs;

  // Window and image geometry registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.image_width  <= DIM_W'(1024);
      cfg_regs.image_height <= DIM_W'(1024);
      cfg_regs.out_width    <= DIM_W'(64);
      cfg_regs.out_height   <= DIM_W'(64);
      cfg_regs.win_left     <= '0;
      cfg_regs.win_top      <= '0;
      cfg_regs.win_width    <= SIZE_W'(16384);
      cfg_regs.win_height   <= SIZE_W'(16384);
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_IMAGE_WIDTH:  cfg_regs.image_width  <= cfg.data.value[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_regs.image_height <= cfg.data.value[DIM_W-1:0];
        REG_OUT_WIDTH:    cfg_regs.out_width    <= cfg.data.value[DIM_W-1:0];
        REG_OUT_HEIGHT:   cfg_regs.out_height   <= cfg.data.value[DIM_W-1:0];
        REG_WIN_LEFT:     cfg_regs.win_left     <= $signed(cfg.data.value);
        REG_WIN_TOP:      cfg_regs.win_top      <= $signed(cfg.data.value);
        REG_WIN_WIDTH:    cfg_regs.win_width    <= cfg.data.value[SIZE_W-1:0];
        REG_WIN_HEIGHT:   cfg_regs.win_height   <= cfg.data.value[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  brs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .req        (req),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  brs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  brs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .rsp       (rsp)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import brs_pkg::*;

  localparam int STORE_N    = 3 * 1024 * 1024;
  localparam int WATCHDOG   = 20000;
  localparam int N_PHASES   = 9;
  localparam int PHASE_PIX  = 220;
  localparam int HOLD_CYC   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  brs_cfg_if cfg ();
  brs_in_if  req ();
  brs_out_if rsp ();

  bilinear_window_resampler_top DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg.sink),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Shadow texel store and which entries hold a loaded value
  bit [7:0] texels [0:STORE_N-1];
  bit       loaded [0:STORE_N-1];

  // Shadow of the register file
  logic [DIM_W-1:0]        img_w, img_h, cells_w, cells_h;
  logic signed [POS_W-1:0] org_x, org_y;
  logic [SIZE_W-1:0]       span_x, span_y;

  in_item_t  send_q [$];
  out_item_t pixel_q [$];

  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks = 0;

  // Directed rows: loads a 2x2 image plus two far texels, then samples it
  typedef struct packed {
    opcode_t     op;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [1:0]  plane;
    logic [7:0]  value;
    logic [9:0]  oc;
    logic [9:0]  orow;
    logic        typed;
    logic [15:0] e0;
    logic [15:0] e1;
    logic [15:0] e2;
  } dir_row_t;

  dir_row_t dir_table [17] = '{
    '{OP_LOAD, 10'd0, 10'd0, 2'd0, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd0, 2'd0, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd0, 10'd1, 2'd0, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd1, 2'd0, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd0, 10'd0, 2'd1, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd0, 2'd1, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd0, 10'd1, 2'd1, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd1, 2'd1, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd0, 10'd0, 2'd2, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd0, 2'd2, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd0, 10'd1, 2'd2, 8'd0,   10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1, 10'd1, 2'd2, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    // plane 3 does not exist: dropped by the block
    '{OP_LOAD, 10'd1023, 10'd1023, 2'd3, 8'd255, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{OP_LOAD, 10'd1023, 10'd1023, 2'd0, 8'd0, 10'd0, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0},
    // cell centre sits half way between all four texels
    '{OP_SAMPLE, 10'd0, 10'd0, 2'd0, 8'd0, 10'd0, 10'd0, 1'b1,
      16'd65280, 16'd0, 16'd32640},
    // far outside the window: clamps onto the bottom right texel
    '{OP_SAMPLE, 10'd0, 10'd0, 2'd0, 8'd0, 10'd1023, 10'd1023, 1'b1,
      16'd65280, 16'd0, 16'd65280},
    '{OP_SAMPLE, 10'd0, 10'd0, 2'd0, 8'd0, 10'd512, 10'd5, 1'b0, 16'd0, 16'd0, 16'd0}
  };

  function automatic int store_addr(int p, longint row, longint col);
    return (p * 1024 + int'(row)) * 1024 + int'(col);
  endfunction

  function automatic longint cell_centre(longint origin, longint span, longint cells,
                                         longint idx);
    longint n;
    n = (cells == 0) ? 1 : cells;
    return origin + ((2 * idx + 1) * span) / (2 * n) - (longint'(1) << (FRAC_BITS - 1));
  endfunction

  function automatic longint edge_clamp(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint dim_limit(logic [DIM_W-1:0] d, int maxv);
    if (d == 0) return 0;
    if (int'(d) > maxv) return maxv - 1;
    return longint'(d) - 1;
  endfunction

  // Neighbor texel indices and blend fractions of one output pixel
  function automatic void locate(input logic [9:0] oc, input logic [9:0] orow,
                                 output longint x0, output longint x1, output longint y0,
                                 output longint y1, output longint fx, output longint fy);
    longint x, y, ix, iy, hx, hy;
    x  = cell_centre(longint'(org_x), longint'(span_x), longint'(cells_w), longint'(oc));
    y  = cell_centre(longint'(org_y), longint'(span_y), longint'(cells_h), longint'(orow));
    ix = x >>> FRAC_BITS;
    iy = y >>> FRAC_BITS;
    fx = x - (ix <<< FRAC_BITS);
    fy = y - (iy <<< FRAC_BITS);
    hx = dim_limit(img_w, MAX_IMAGE_WIDTH);
    hy = dim_limit(img_h, MAX_IMAGE_HEIGHT);
    x0 = edge_clamp(ix, hx);
    x1 = edge_clamp(ix + 1, hx);
    y0 = edge_clamp(iy, hy);
    y1 = edge_clamp(iy + 1, hy);
  endfunction

  function automatic out_item_t blend_pixel(logic [9:0] oc, logic [9:0] orow);
    out_item_t o;
    longint x0, x1, y0, y1, fx, fy, a, b, c, d, c1, c2, r;
    logic [15:0] v [3];
    locate(oc, orow, x0, x1, y0, y1, fx, fy);
    for (int p = 0; p < 3; p++) begin
      a  = texels[store_addr(p, y0, x0)];
      b  = texels[store_addr(p, y0, x1)];
      c  = texels[store_addr(p, y1, x0)];
      d  = texels[store_addr(p, y1, x1)];
      c1 = (a <<< FRAC_BITS) + (b - a) * fx;
      c2 = (c <<< FRAC_BITS) + (d - c) * fx;
      r  = (c1 <<< FRAC_BITS) + (c2 - c1) * fy;
      if (r < 0) r = 0;
      v[p] = 16'(r >> (2 * FRAC_BITS - 8));
    end
    o.sample_col   = oc;
    o.sample_row   = orow;
    o.value_plane0 = v[0];
    o.value_plane1 = v[1];
    o.value_plane2 = v[2];
    return o;
  endfunction

  task automatic queue_load(input logic [9:0] col, input logic [9:0] row,
                            input logic [1:0] p, input logic [7:0] val);
    in_item_t it;
    it = '0;
    it.opcode      = OP_LOAD;
    it.texel_col   = col;
    it.texel_row   = row;
    it.plane       = p;
    it.texel_value = val;
    send_q.push_back(it);
    if (p < PLANES) begin
      texels[store_addr(p, row, col)] = val;
      loaded[store_addr(p, row, col)] = 1'b1;
    end
  endtask

  // Loads any neighbor never written, then queues the sample
  task automatic queue_sample(input logic [9:0] oc, input logic [9:0] orow);
    in_item_t it;
    longint x0, x1, y0, y1, fx, fy;
    longint xs [2];
    longint ys [2];
    locate(oc, orow, x0, x1, y0, y1, fx, fy);
    xs = '{x0, x1};
    ys = '{y0, y1};
    for (int p = 0; p < PLANES; p++)
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++)
          if (!loaded[store_addr(p, ys[j], xs[i])])
            queue_load(10'(xs[i]), 10'(ys[j]), 2'(p), 8'($urandom));
    it = '0;
    it.opcode  = OP_SAMPLE;
    it.out_col = oc;
    it.out_row = orow;
    send_q.push_back(it);
    pixel_q.push_back(blend_pixel(oc, orow));
  endtask

  // Register writes back to back; valid drops only after the last one
  task automatic write_regs(input logic [POS_W-1:0] vals [8]);
    cfg_index_t order [8];
    order = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_OUT_WIDTH, REG_OUT_HEIGHT,
              REG_WIN_LEFT, REG_WIN_TOP, REG_WIN_WIDTH, REG_WIN_HEIGHT};
    for (int i = 0; i < 8; i++) begin
      cfg.valid      <= 1'b1;
      cfg.data.index <= order[i];
      cfg.data.value <= vals[i];
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
    img_w   = vals[0][DIM_W-1:0];
    img_h   = vals[1][DIM_W-1:0];
    cells_w = vals[2][DIM_W-1:0];
    cells_h = vals[3][DIM_W-1:0];
    org_x   = vals[4];
    org_y   = vals[5];
    span_x  = vals[6][SIZE_W-1:0];
    span_y  = vals[7][SIZE_W-1:0];
  endtask

  // Drains send_q onto req with random gaps
  task automatic drive_items();
    in_item_t it;
    while (send_q.size() > 0) begin
      it = send_q.pop_front();
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
      req.valid <= 1'b1;
      req.data  <= it;
      do @(posedge clk); while (!req.ready);
    end
    req.valid <= 1'b0;
  endtask

  // Block is idle once every pixel is back and the pipe has flushed
  task automatic wait_drained();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(int small_max);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'd2047;
      2: return 11'd1024;
      default: return DIM_W'($urandom_range(1, small_max));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  int hold_left = 0;
  int holds_seen = 0;
  always @(posedge clk) begin
    if (hold_asks != holds_seen) begin
      holds_seen <= hold_asks;
      hold_left  <= HOLD_CYC;
      rsp.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker: in order, field by field
  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.data;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result col %0d row %0d", got.sample_col, got.sample_row);
      end else begin
        want = pixel_q.pop_front();
        if (got.sample_col !== want.sample_col || got.sample_row !== want.sample_row ||
            got.value_plane0 !== want.value_plane0 ||
            got.value_plane1 !== want.value_plane1 ||
            got.value_plane2 !== want.value_plane2) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d,%0d %h %h %h got %0d,%0d %h %h %h",
                     want.sample_col, want.sample_row, want.value_plane0,
                     want.value_plane1, want.value_plane2, got.sample_col,
                     got.sample_row, got.value_plane0, got.value_plane1,
                     got.value_plane2);
        end
      end
    end
  end

  // Watchdog: any handshake counts as progress
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [POS_W-1:0] regs [8];
    int eff_w, n;
    dir_row_t r;
    out_item_t o;

    req.valid <= 1'b0;
    req.data  <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x2 image, one cell covering it all
    regs = '{21'd2, 21'd2, 21'd1, 21'd1, 21'd0, 21'd0, 21'd512, 21'd512};
    write_regs(regs);
    foreach (dir_table[i]) begin
      r = dir_table[i];
      if (r.op == OP_LOAD) begin
        queue_load(r.col, r.row, r.plane, r.value);
      end else if (r.typed) begin
        send_q.push_back('{opcode: OP_SAMPLE, texel_col: '0, texel_row: '0, plane: '0,
                           texel_value: '0, out_col: r.oc, out_row: r.orow});
        o = '{sample_col: r.oc, sample_row: r.orow, value_plane0: r.e0,
              value_plane1: r.e1, value_plane2: r.e2};
        pixel_q.push_back(o);
      end else begin
        queue_sample(r.oc, r.orow);
      end
    end
    drive_items();
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Three idling regimes in turn
      case (ph * 3 / N_PHASES)
        0: begin tx_idle_pct = 30; rx_idle_pct = 76; end
        1: begin tx_idle_pct = 76; rx_idle_pct = 30; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      if (ph == 0) begin
        // zero sizes act as one, oversize acts as max, window at its extremes
        regs = '{21'd0, 21'd2047, 21'd0, 21'd2047, 21'h100000, 21'h0FFFFF,
                 21'd1, 21'h0FFFFF};
      end else if (ph == 1) begin
        regs = '{21'd1024, 21'd0, 21'd2047, 21'd0, 21'h0FFFFF, 21'h100000,
                 21'h0FFFFF, 21'd1};
      end else begin
        regs[0] = POS_W'(pick_dim(16));
        regs[1] = POS_W'(pick_dim(16));
        regs[2] = POS_W'(pick_dim(40));
        regs[3] = POS_W'(pick_dim(40));
        eff_w   = 16;
        regs[4] = POS_W'($urandom_range(0, 2 * eff_w * 256) - eff_w * 256);
        regs[5] = POS_W'($urandom_range(0, 2 * eff_w * 256) - eff_w * 256);
        regs[6] = POS_W'($urandom_range(1, 2 * eff_w * 256));
        regs[7] = POS_W'($urandom_range(1, 2 * eff_w * 256));
        if ($urandom_range(0, 3) == 0) regs[4] = POS_W'($urandom);
        if ($urandom_range(0, 3) == 0) regs[7] = POS_W'($urandom_range(1, 20'hFFFFF));
      end
      write_regs(regs);

      for (int k = 0; k < PHASE_PIX; k++) begin
        // some stray loads anywhere, plane 3 included
        if ($urandom_range(0, 9) == 0)
          queue_load(10'($urandom), 10'($urandom), 2'($urandom), 8'($urandom));
        n = (cells_w == 0) ? 1 : int'(cells_w);
        if ($urandom_range(0, 9) < 8)
          queue_sample(10'($urandom_range(0, (n > 1024 ? 1024 : n) - 1)),
                       10'($urandom_range(0, ((cells_h == 0) ? 1 :
                           (cells_h > 1024 ? 1024 : int'(cells_h))) - 1)));
        else
          queue_sample(10'($urandom), 10'($urandom));
      end

      // Long receiver hold-off while the sender keeps pushing
      if (ph == N_PHASES - 2) hold_asks++;
      drive_items();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[bilinear_window_resampler_top.f]
rtl/brs_pkg.sv
rtl/brs_if.sv
rtl/brs_divider.sv
rtl/brs_front.sv
rtl/brs_queue.sv
rtl/brs_back.sv
rtl/bilinear_window_resampler_top.sv
sim/tb_top.sv
